>>> sv/rlsh_pkg.sv
// Shared types, constants and the mixing function of the string hash.
`default_nettype none
package rlsh_pkg;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned SUM_W     = 8;
  localparam int unsigned OUT_IDX_W = 4;
  localparam int unsigned TAKEN_W   = 8;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = 2;
  localparam int unsigned Q_CNT_W   = 3;

  localparam logic [SUM_W-1:0]   SUM_START = 8'd78;
  localparam logic [SUM_W-1:0]   MUL_CONST = 8'd83;
  localparam logic [SUM_W-1:0]   ADD_CONST = 8'd89;
  localparam logic [TAKEN_W-1:0] MAX_TAKEN = 8'd255;
  localparam logic [CFG_W-1:0]   LEN_RESET = 5'd3;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // Command passed from the front end to the back end through the queue.
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // Rotate right by two, multiply by 83 and add 89, all modulo 256.
  function automatic logic [SUM_W-1:0] mix_step(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0]   rot;
    logic [2*SUM_W-1:0] prod;
    rot  = {s[1:0], s[SUM_W-1:2]};
    prod = (2*SUM_W)'(rot) * (2*SUM_W)'(MUL_CONST);
    return prod[SUM_W-1:0] + ADD_CONST;
  endfunction

endpackage
`default_nettype wire

>>> sv/rlsh_front.sv
// Front end: accepts input items, drops the ones that cannot change the hash.
`default_nettype none
module rlsh_front
  import rlsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_operation,
  input  wire logic [CHAR_W-1:0] in_char_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_push_data
);

  logic               ended_r, ended_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ended_nxt      = ended_r;
    taken_nxt      = taken_r;
    q_push         = 1'b0;
    q_push_data.op = op_t'(in_operation);
    q_push_data.ch = in_char_byte;
    if (accept) begin
      if (op_t'(in_operation) == OP_FINISH) begin
        q_push    = 1'b1;
        ended_nxt = 1'b0;
        taken_nxt = '0;
      end else if (!ended_r) begin
        if (in_char_byte == '0) begin
          ended_nxt = 1'b1;
        end else if (taken_r != MAX_TAKEN) begin
          q_push    = 1'b1;
          taken_nxt = taken_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
      taken_r <= '0;
    end else begin
      ended_r <= ended_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/rlsh_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module rlsh_queue
  import rlsh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/rlsh_back.sv
// Back end: runs the mixing step into the hash memory and streams the hash out.
`default_nettype none
module rlsh_back
  import rlsh_pkg::*;
#(
  parameter int unsigned MAX_HASH_BYTES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CFG_W-1:0]     cfg_len,
  input  wire logic                 q_empty,
  input  wire cmd_t                 q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SUM_W-1:0]          out_hash_byte,
  output logic [OUT_IDX_W-1:0]      out_byte_index,
  output logic                      out_last_byte
);

  localparam int unsigned IDX_W = (MAX_HASH_BYTES > 1) ? $clog2(MAX_HASH_BYTES) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_HASH_BYTES + 1);
  localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ABS_WR = 3'b010,
    S_EMIT   = 3'b100
  } back_state_t;

  back_state_t               state_r, state_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [IDX_W-1:0]          slot_r, slot_nxt;
  logic [IDX_W-1:0]          wpos_r, wpos_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic [MAX_HASH_BYTES-1:0] valid_r, valid_nxt;
  logic [SUM_W-1:0]          mem_r [MAX_HASH_BYTES];
  logic [SUM_W-1:0]          rd_r;
  logic                      rdv_r;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      mem_we;
  logic [SUM_W-1:0]          wr_data;
  logic [SUM_W-1:0]          rd_val;

  logic                      out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]          out_hash_r;
  logic [OUT_IDX_W-1:0]      out_idx_r;
  logic                      out_last_r;
  logic                      out_free;
  logic                      out_load;

  logic [CMP_W-1:0]          cfg_ext;
  logic [CMP_W-1:0]          eff_wide;
  logic [LEN_W-1:0]          len;
  logic [IDX_W-1:0]          pos;
  logic [LEN_W-1:0]          pos_inc;
  logic                      k_last;

  // Effective array length: zero counts as one, large values are clamped.
  always_comb begin
    cfg_ext = CMP_W'(cfg_len);
    if (cfg_ext == '0) begin
      eff_wide = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_HASH_BYTES)) begin
      eff_wide = CMP_W'(MAX_HASH_BYTES);
    end else begin
      eff_wide = cfg_ext;
    end
    len = eff_wide[LEN_W-1:0];
  end

  // A slot left beyond a shortened length wraps to entry zero.
  assign pos     = (LEN_W'(slot_r) >= len) ? '0 : slot_r;
  assign pos_inc = LEN_W'(pos) + 1'b1;
  assign k_last  = ((LEN_W'(k_r) + 1'b1) == len);

  assign rd_val   = rdv_r ? rd_r : '0;
  assign wr_data  = rd_val + sum_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    slot_nxt  = slot_r;
    wpos_nxt  = wpos_r;
    k_nxt     = k_r;
    valid_nxt = valid_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = pos;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          rd_en = 1'b1;
          if (q_data.op == OP_FINISH) begin
            rd_addr   = '0;
            k_nxt     = '0;
            state_nxt = S_EMIT;
          end else begin
            sum_nxt   = mix_step(sum_r + q_data.ch);
            wpos_nxt  = pos;
            slot_nxt  = (pos_inc >= len) ? '0 : IDX_W'(pos_inc);
            state_nxt = S_ABS_WR;
          end
        end
      end
      S_ABS_WR: begin
        mem_we            = 1'b1;
        valid_nxt[wpos_r] = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (k_last) begin
            valid_nxt = '0;
            sum_nxt   = SUM_START;
            slot_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt   = k_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= SUM_START;
      slot_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wpos_r <= wpos_nxt;
    k_r    <= k_nxt;
    if (out_load) begin
      out_hash_r <= rd_val;
      out_idx_r  <= OUT_IDX_W'(k_r);
      out_last_r <= k_last;
    end
  end

  // Hash memory with a registered read port; unwritten entries read as zero
  // through the valid bits.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wpos_r] <= wr_data;
    end
    if (rd_en) begin
      rd_r  <= mem_r[rd_addr];
      rdv_r <= valid_r[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_byte  = out_hash_r;
  assign out_byte_index = out_idx_r;
  assign out_last_byte  = out_last_r;

endmodule
`default_nettype wire

>>> sv/rotate_lcg_string_hash.sv
// Top level of the rotate-and-multiply string hash.
//
// Folds a byte string into a hash array of up to MAX_HASH_BYTES bytes. An
// absorb item (operation 0) adds one character; a zero character ends the
// string and characters after it, or after the 255th, are ignored until a
// finish item (operation 1), which emits one result per array byte with
// last_byte set on the final one, then starts a fresh hash. The front end
// takes one item per cycle while the four-entry command queue is not full and
// drops ignored characters there at once. The back end handles an absorbed
// character in two steps (a registered read of the hash memory, then the
// write-back of the sum) and, for a finish, starts the first read and then
// gives one result per cycle while the output is not stalled. The array length
// register is written through cfg_wr_en and cfg_array_length and should only
// change while the block is idle; zero is used as one and values above
// MAX_HASH_BYTES are clamped.
`default_nettype none
module rotate_lcg_string_hash
  import rlsh_pkg::*;
#(
  parameter int unsigned MAX_HASH_BYTES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_array_length,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_operation,
  input  wire logic [CHAR_W-1:0]    in_char_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SUM_W-1:0]          out_hash_byte,
  output logic [OUT_IDX_W-1:0]      out_byte_index,
  output logic                      out_last_byte
);

  logic [CFG_W-1:0] array_length_r;
  logic             q_full;
  logic             q_push;
  cmd_t             q_push_data;
  logic             q_pop;
  cmd_t             q_pop_data;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      array_length_r <= cfg_array_length;
    end
  end

  rlsh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_data  (q_push_data)
  );

  rlsh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  rlsh_back #(
    .MAX_HASH_BYTES (MAX_HASH_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_len        (array_length_r),
    .q_empty        (q_empty),
    .q_data         (q_pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_byte  (out_hash_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte)
  );

endmodule
`default_nettype wire
